### hdl/izz_pkg.sv
// shared constants and types for the inverse zigzag reorder block
package izz_pkg;

  // bits of one block value
  localparam int ValueBits = 8;

  // bits of the row and column result ports
  localparam int CoordOutBits = 3;

  // back end sequencer states
  typedef enum logic {
    BACK_LOAD,
    BACK_DRAIN
  } izz_back_state_e;

endpackage

### hdl/izz_front.sv
// front end: walks the zigzag path and tags each value with its raster address
module izz_front #(
  parameter int SIDE      = 8,
  parameter int WORD_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [izz_pkg::ValueBits-1:0] value_i,
  output logic [WORD_BITS-1:0]          word_o
);
  import izz_pkg::*;

  localparam int CoordBits = $clog2(SIDE);
  localparam int Cells     = SIDE * SIDE;
  localparam int AddrBits  = $clog2(Cells);
  localparam logic [CoordBits-1:0] LastCoord = CoordBits'(SIDE - 1);
  localparam logic [AddrBits-1:0]  LastCount = AddrBits'(Cells - 1);
  localparam logic [AddrBits-1:0]  SideAddr  = AddrBits'(SIDE);

  logic [CoordBits-1:0] row_q, row_d;
  logic [CoordBits-1:0] col_q, col_d;
  logic                 dir_q, dir_d;
  logic [AddrBits-1:0]  count_q, count_d;
  logic [AddrBits-1:0]  addr;
  logic                 last;

  // raster place of the current scan position
  assign addr = AddrBits'(row_q) * SideAddr + AddrBits'(col_q);
  assign last = (count_q == LastCount);

  // word handed to the queue: last flag, raster address, value
  assign word_o = {last, addr, value_i};

  // scan position step
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    dir_d   = dir_q;
    count_d = count_q;
    if (push_i) begin
      if (last) begin
        row_d   = '0;
        col_d   = '0;
        dir_d   = 1'b0;
        count_d = '0;
      end else begin
        count_d = count_q + 1'b1;
        if (!dir_q) begin
          // moving up-right
          if (col_q == LastCoord) begin
            row_d = row_q + 1'b1;
            dir_d = 1'b1;
          end else if (row_q == '0) begin
            col_d = col_q + 1'b1;
            dir_d = 1'b1;
          end else begin
            row_d = row_q - 1'b1;
            col_d = col_q + 1'b1;
          end
        end else begin
          // moving down-left
          if (row_q == LastCoord) begin
            col_d = col_q + 1'b1;
            dir_d = 1'b0;
          end else if (col_q == '0) begin
            row_d = row_q + 1'b1;
            dir_d = 1'b0;
          end else begin
            row_d = row_q + 1'b1;
            col_d = col_q - 1'b1;
          end
        end
      end
    end
  end

  // scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      dir_q   <= 1'b0;
      count_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      dir_q   <= dir_d;
      count_q <= count_d;
    end
  end

endmodule

### hdl/izz_queue.sv
// short word queue between the front end and the back end
module izz_queue #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  import izz_pkg::*;

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

  logic [WIDTH-1:0]   slot_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("word pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("word popped from empty queue");
`endif

endmodule

### hdl/izz_back.sv
// back end: block store writes and raster order readout
module izz_back #(
  parameter int SIDE      = 8,
  parameter int WORD_BITS = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  logic [WORD_BITS-1:0]             word_i,
  output logic                             pop_o,
  output logic                             result_valid_o,
  output logic [izz_pkg::ValueBits-1:0]    raster_value_o,
  output logic [izz_pkg::CoordOutBits-1:0] out_row_o,
  output logic [izz_pkg::CoordOutBits-1:0] out_col_o,
  output logic                             block_last_o
);
  import izz_pkg::*;

  localparam int CoordBits = $clog2(SIDE);
  localparam int Cells     = SIDE * SIDE;
  localparam int AddrBits  = $clog2(Cells);
  localparam logic [CoordBits-1:0] LastCoord = CoordBits'(SIDE - 1);

  izz_back_state_e state_q, state_d;

  logic [ValueBits-1:0] wr_value;
  logic [AddrBits-1:0]  wr_addr;
  logic                 wr_last;
  logic                 issue;
  logic                 final_issue;

  logic [ValueBits-1:0] store [Cells];
  logic [ValueBits-1:0] rdata_q;

  logic [AddrBits-1:0]  rd_addr_q, rd_addr_d;
  logic [CoordBits-1:0] rd_row_q, rd_row_d;
  logic [CoordBits-1:0] rd_col_q, rd_col_d;

  logic                 valid_q;
  logic [CoordBits-1:0] row_q;
  logic [CoordBits-1:0] col_q;
  logic                 last_q;

  // unpack the queued word
  assign wr_value = word_i[ValueBits-1:0];
  assign wr_addr  = word_i[ValueBits +: AddrBits];
  assign wr_last  = word_i[ValueBits + AddrBits];

  assign final_issue = (rd_row_q == LastCoord) && (rd_col_q == LastCoord);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BACK_LOAD: begin
        if (!empty_i && wr_last) begin
          state_d = BACK_DRAIN;
        end
      end
      BACK_DRAIN: begin
        if (final_issue) begin
          state_d = BACK_LOAD;
        end
      end
      default: state_d = BACK_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o = 1'b0;
    issue = 1'b0;
    case (state_q)
      BACK_LOAD:  pop_o = !empty_i;
      BACK_DRAIN: issue = 1'b1;
      default: begin
        pop_o = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  // raster read position
  always_comb begin
    rd_addr_d = rd_addr_q;
    rd_row_d  = rd_row_q;
    rd_col_d  = rd_col_q;
    if (issue) begin
      if (final_issue) begin
        rd_addr_d = '0;
        rd_row_d  = '0;
        rd_col_d  = '0;
      end else begin
        rd_addr_d = rd_addr_q + 1'b1;
        if (rd_col_q == LastCoord) begin
          rd_col_d = '0;
          rd_row_d = rd_row_q + 1'b1;
        end else begin
          rd_col_d = rd_col_q + 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BACK_LOAD;
      rd_addr_q <= '0;
      rd_row_q  <= '0;
      rd_col_q  <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      rd_row_q  <= rd_row_d;
      rd_col_q  <= rd_col_d;
      valid_q   <= issue;
    end
  end

  // block store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store[wr_addr] <= wr_value;
    end
    if (issue) begin
      rdata_q <= store[rd_addr_q];
    end
  end

  // result tag registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      row_q  <= rd_row_q;
      col_q  <= rd_col_q;
      last_q <= final_issue;
    end
  end

  assign result_valid_o = valid_q;
  assign raster_value_o = rdata_q;
  assign out_row_o      = CoordOutBits'(row_q);
  assign out_col_o      = CoordOutBits'(col_q);
  assign block_last_o   = last_q;

`ifndef SYNTHESIS
  a_result_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == BACK_DRAIN))
    else $error("result word without a readout cycle");
  a_no_pop_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BACK_DRAIN) |-> !pop_o)
    else $error("store written during readout");
  a_last_at_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (row_q == LastCoord && col_q == LastCoord))
    else $error("block last flag away from the final cell");
`endif

endmodule

### hdl/inverse_zigzag_reorder.sv
// top level of the inverse zigzag reorder block
//
// Input channel: a value word is taken at a rising edge where start is high
// and busy is low. Values of one SIDE by SIDE block arrive in zigzag order.
// Result channel: each raster word is shown for one cycle with result_valid_o
// high, with its row and column; block_last_o marks the block's final word.
// The receiver cannot stall, so results simply stream out.
// Load: one value per cycle while the back end is storing; the front end tags
// each value with its raster address and a two-word queue decouples it.
// Readout: the last value passes the queue into the store as readout begins, and
// SIDE*SIDE words then follow from registered reads on consecutive cycles, set by
// the single read port of the block store. During readout busy rises once the
// queue is full, so next-block values beyond those it holds wait for readout to end.
// Reset clears the scan position, the queue and the readout sequencer; the
// block store needs no clearing since every entry is written before it is read.
module inverse_zigzag_reorder #(
  parameter int SIDE = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [izz_pkg::ValueBits-1:0]    zigzag_value_i,
  output logic                             result_valid_o,
  output logic [izz_pkg::ValueBits-1:0]    raster_value_o,
  output logic [izz_pkg::CoordOutBits-1:0] out_row_o,
  output logic [izz_pkg::CoordOutBits-1:0] out_col_o,
  output logic                             block_last_o
);
  import izz_pkg::*;

  localparam int AddrBits  = $clog2(SIDE * SIDE);
  localparam int WordBits  = 1 + AddrBits + ValueBits;
  localparam int QueueSize = 2;

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  logic [WordBits-1:0] front_word;
  logic [WordBits-1:0] back_word;

  // accept handshake
  assign busy = full;
  assign push = start && !full;

  // zigzag walk and address tagging
  izz_front #(
    .SIDE      (SIDE),
    .WORD_BITS (WordBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .value_i (zigzag_value_i),
    .word_o  (front_word)
  );

  // decoupling queue
  izz_queue #(
    .WIDTH (WordBits),
    .DEPTH (QueueSize)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_word),
    .pop_i   (pop),
    .data_o  (back_word),
    .full_o  (full),
    .empty_o (empty)
  );

  // block store and raster readout
  izz_back #(
    .SIDE      (SIDE),
    .WORD_BITS (WordBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .word_i         (back_word),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .raster_value_o (raster_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .block_last_o   (block_last_o)
  );

endmodule

### verif/izz_raster_checker.sv
// scoreboard that predicts and checks the raster words of the inverse zigzag reorder
module izz_raster_checker #(
  parameter int SIDE = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [izz_pkg::ValueBits-1:0]    zigzag_value_i,
  input  logic                             result_valid_i,
  input  logic [izz_pkg::ValueBits-1:0]    raster_value_i,
  input  logic [izz_pkg::CoordOutBits-1:0] out_row_i,
  input  logic [izz_pkg::CoordOutBits-1:0] out_col_i,
  input  logic                             block_last_i,
  output int                               fail_count_o,
  output int                               pending_words_o
);
  import izz_pkg::*;

  localparam int Cells = SIDE * SIDE;

  typedef enum logic {
    SCAN_UP_RIGHT,
    SCAN_DOWN_LEFT
  } scan_dir_e;

  typedef struct packed {
    logic [ValueBits-1:0]    value;
    logic [CoordOutBits-1:0] row;
    logic [CoordOutBits-1:0] col;
    logic                    last;
  } raster_word_t;

  // predicted block state
  logic [ValueBits-1:0]    block_store [Cells];
  int                      load_count;
  logic [CoordOutBits-1:0] scan_row;
  logic [CoordOutBits-1:0] scan_col;
  scan_dir_e               scan_dir;

  raster_word_t raster_expected_q [$];
  int           fail_total = 0;

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    fail_total++;
    $display("%0t izz check: %s", $time, msg);
  endtask

  // store one zigzag word at its raster place; the last word of a block queues the block
  task automatic load_zigzag_word(input logic [ValueBits-1:0] value);
    raster_word_t w;
    block_store[int'(scan_row) * SIDE + int'(scan_col)] = value;
    if (load_count + 1 < Cells) begin
      load_count++;
      // walk the zigzag path, turning at the block edges
      if (scan_dir == SCAN_UP_RIGHT) begin
        if (scan_col == CoordOutBits'(SIDE - 1)) begin
          scan_row++;
          scan_dir = SCAN_DOWN_LEFT;
        end else if (scan_row == '0) begin
          scan_col++;
          scan_dir = SCAN_DOWN_LEFT;
        end else begin
          scan_row--;
          scan_col++;
        end
      end else begin
        if (scan_row == CoordOutBits'(SIDE - 1)) begin
          scan_col++;
          scan_dir = SCAN_UP_RIGHT;
        end else if (scan_col == '0) begin
          scan_row++;
          scan_dir = SCAN_UP_RIGHT;
        end else begin
          scan_row++;
          scan_col--;
        end
      end
    end else begin
      // block complete: emit in raster order
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE; c++) begin
          w.value = block_store[r * SIDE + c];
          w.row   = CoordOutBits'(r);
          w.col   = CoordOutBits'(c);
          w.last  = (r == SIDE - 1) && (c == SIDE - 1);
          raster_expected_q.push_back(w);
        end
      end
      load_count = 0;
      scan_row   = '0;
      scan_col   = '0;
      scan_dir   = SCAN_UP_RIGHT;
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    raster_word_t want;
    if (!rst_ni) begin
      load_count = 0;
      scan_row   = '0;
      scan_col   = '0;
      scan_dir   = SCAN_UP_RIGHT;
      raster_expected_q.delete();
    end else begin
      if (start_i && !busy_i) begin
        load_zigzag_word(zigzag_value_i);
      end
      if (result_valid_i) begin
        if (raster_expected_q.size() == 0) begin
          report_mismatch($sformatf("word r%0d c%0d value %0d with none expected",
                                    out_row_i, out_col_i, raster_value_i));
        end else begin
          want = raster_expected_q.pop_front();
          if (raster_value_i !== want.value) begin
            report_mismatch($sformatf("raster_value at r%0d c%0d got %0d expected %0d",
                                      want.row, want.col, raster_value_i, want.value));
          end
          if (out_row_i !== want.row) begin
            report_mismatch($sformatf("out_row got %0d expected %0d", out_row_i, want.row));
          end
          if (out_col_i !== want.col) begin
            report_mismatch($sformatf("out_col got %0d expected %0d", out_col_i, want.col));
          end
          if (block_last_i !== want.last) begin
            report_mismatch($sformatf("block_last at r%0d c%0d got %0b expected %0b",
                                      want.row, want.col, block_last_i, want.last));
          end
        end
      end
    end
    fail_count_o    <= fail_total;
    pending_words_o <= raster_expected_q.size();
  end

endmodule

### verif/tb_inverse_zigzag_reorder.sv
// testbench top: drives zigzag words into the inverse zigzag reorder and gives the verdict
module tb_inverse_zigzag_reorder;
  import izz_pkg::*;

  localparam int SIDE = 8;
  localparam int Cells = SIDE * SIDE;
  localparam int BlockCount = 5;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 20;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [ValueBits-1:0]    zigzag_value_i;
  logic                    result_valid_o;
  logic [ValueBits-1:0]    raster_value_o;
  logic [CoordOutBits-1:0] out_row_o;
  logic [CoordOutBits-1:0] out_col_o;
  logic                    block_last_o;

  int   fail_count;
  int   pending_words;
  int   stall_cycles = 0;
  logic idle_on;

  inverse_zigzag_reorder #(
    .SIDE(SIDE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .zigzag_value_i(zigzag_value_i),
    .result_valid_o(result_valid_o),
    .raster_value_o(raster_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .block_last_o  (block_last_o)
  );

  izz_raster_checker #(
    .SIDE(SIDE)
  ) raster_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .zigzag_value_i (zigzag_value_i),
    .result_valid_i (result_valid_o),
    .raster_value_i (raster_value_o),
    .out_row_i      (out_row_o),
    .out_col_i      (out_col_o),
    .block_last_i   (block_last_o),
    .fail_count_o   (fail_count),
    .pending_words_o(pending_words)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on cycles where no word moves on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_inverse_zigzag_reorder: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one word, maybe after an idle burst, and wait until it is taken
  task automatic send_word(input logic [ValueBits-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start          <= 1'b1;
    zigzag_value_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [ValueBits-1:0] directed_q [$];
    logic [ValueBits-1:0] value;
    int                   spread;
    int                   offset;
    bit                   distinct_block;
    rst_ni         = 1'b0;
    start          = 1'b0;
    zigzag_value_i = '0;
    idle_on        = 1'b0;
    distinct_block = 1'b0;
    spread         = 1;
    offset         = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes and walking bit patterns open the first block
    directed_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    for (int b = 0; b < ValueBits; b++) begin
      directed_q.push_back(ValueBits'(1) << b);
      directed_q.push_back(~(ValueBits'(1) << b));
    end

    for (int i = 0; i < BlockCount * Cells; i++) begin
      if (i % Cells == 0) begin
        // a block of distinct values exposes any misplaced word
        distinct_block = (i == Cells) || ($urandom_range(0, 1) == 1);
        spread         = 2 * $urandom_range(0, 127) + 1;
        offset         = $urandom_range(0, 255);
      end
      // idle in stretches, none in the last block
      if (i % 16 == 0) begin
        idle_on = (i < (BlockCount - 1) * Cells) && ($urandom_range(0, 3) != 0);
      end
      if (i < directed_q.size()) begin
        value = directed_q[i];
      end else if (distinct_block) begin
        value = ValueBits'((i % Cells) * spread + offset);
      end else begin
        value = ValueBits'($urandom);
      end
      send_word(value);
    end
    start <= 1'b0;
    @(posedge clk_i);

    // drain outstanding raster words, then allow for stray ones
    while (pending_words != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_inverse_zigzag_reorder: PASS");
    end else begin
      $display("tb_inverse_zigzag_reorder: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/izz_pkg.sv
hdl/izz_front.sv
hdl/izz_queue.sv
hdl/izz_back.sv
hdl/inverse_zigzag_reorder.sv
verif/izz_raster_checker.sv
verif/tb_inverse_zigzag_reorder.sv
